[rtl/core/sepm_pkg.sv]
// ----------------------------------------------------------------------------
// sepm_pkg
// Shared types and constants of the stream exact-pattern matcher.
// ----------------------------------------------------------------------------
package sepm_pkg;

  localparam int PatBytes = 32;                   // bytes held by the pattern registers
  localparam int PatIdxW  = $clog2(PatBytes);     // index into the pattern bytes
  localparam int LenW     = 6;                    // pattern_length register width
  localparam int OffW     = 48;                   // file offset and match count width
  localparam int CfgDataW = 64;
  localparam int CfgAddrW = 6;                    // five 64-bit registers at 8*i
  localparam int MinLen   = 2;                    // shorter patterns never match

  typedef enum logic [2:0] {
    RegPat0 = 3'd0,
    RegPat1 = 3'd1,
    RegPat2 = 3'd2,
    RegPat3 = 3'd3,
    RegLen  = 3'd4
  } sepm_reg_e;

  // Control broadcast to every window cell
  typedef struct packed {
    logic            shift;   // a transaction is taken this cycle
    logic            clr;     // new file: window restarts from zero
    logic [LenW-1:0] len;     // effective pattern length
  } sepm_cell_ctl_t;

endpackage

[rtl/core/sepm_in_if.sv]
// ----------------------------------------------------------------------------
// sepm_in_if
// Byte stream channel: one file byte and its new-file flag per transaction.
// ----------------------------------------------------------------------------
interface sepm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_file;

  modport source (output valid, output data_byte, output new_file, input ready);
  modport sink   (input valid, input data_byte, input new_file, output ready);
endinterface

[rtl/core/sepm_out_if.sv]
// ----------------------------------------------------------------------------
// sepm_out_if
// Result channel: match flag, match start offset and running match count.
// ----------------------------------------------------------------------------
interface sepm_out_if import sepm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            match_found;
  logic [OffW-1:0] match_start;
  logic [OffW-1:0] match_total;

  modport source (output valid, output match_found, output match_start,
                  output match_total, input ready);
  modport sink   (input valid, input match_found, input match_start,
                  input match_total, output ready);
endinterface

[rtl/core/sepm_cfg.sv]
// ----------------------------------------------------------------------------
// sepm_cfg
// APB register file: four 64-bit pattern words and the pattern length.
// ----------------------------------------------------------------------------
module sepm_cfg import sepm_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CfgAddrW-1:0]           paddr,
  input  logic [CfgDataW-1:0]           pwdata,
  output logic [CfgDataW-1:0]           prdata,
  output logic                          pready,
  output logic [PatBytes-1:0][7:0]      pat_o,
  output logic [LenW-1:0]               len_o
);

  logic [3:0][CfgDataW-1:0] word_q;
  logic [LenW-1:0]          len_q;
  logic                     wr_en;
  sepm_reg_e                reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = sepm_reg_e'(paddr[CfgAddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      len_q  <= LenW'(MinLen);
    end else if (wr_en) begin
      unique case (reg_sel)
        RegPat0: word_q[0] <= pwdata;
        RegPat1: word_q[1] <= pwdata;
        RegPat2: word_q[2] <= pwdata;
        RegPat3: word_q[3] <= pwdata;
        RegLen:  len_q     <= pwdata[LenW-1:0];
        default: ;  // unmapped: write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegPat0: prdata = word_q[0];
      RegPat1: prdata = word_q[1];
      RegPat2: prdata = word_q[2];
      RegPat3: prdata = word_q[3];
      RegLen:  prdata = CfgDataW'(len_q);
      default: prdata = '0;
    endcase
  end

  assign pat_o = word_q;  // byte 0 sits in the low bits of word 0
  assign len_o = len_q;

endmodule

[rtl/core/sepm_cell.sv]
// ----------------------------------------------------------------------------
// sepm_cell
// One window position: holds a byte, takes its neighbor's byte on a shift and
// checks the incoming byte against the pattern byte aligned to this position.
// ----------------------------------------------------------------------------
module sepm_cell import sepm_pkg::*; #(
  parameter int Idx    = 0,
  parameter bit IsHead = 1'b0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sepm_cell_ctl_t           ctl_i,
  input  logic [PatBytes-1:0][7:0] pat_i,
  input  logic [7:0]               nb_i,     // byte from the newer neighbor
  output logic [7:0]               byte_o,
  output logic                     eq_o
);

  localparam logic [LenW-1:0] Pos = LenW'(Idx);

  logic [7:0]      byte_q;
  logic [7:0]      byte_d;
  logic [LenW-1:0] diff;
  logic            in_use;

  // The head takes the new byte itself; the others restart at zero on a new file
  assign byte_d = (!IsHead && ctl_i.clr) ? 8'h00 : nb_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctl_i.shift) begin
      byte_q <= byte_d;
    end
  end

  // Position j holds pattern byte len-1-j when the pattern ends at the newest byte
  always_comb begin
    diff   = ctl_i.len - Pos - LenW'(1);
    in_use = Pos < ctl_i.len;
    eq_o   = !in_use || (byte_d == pat_i[diff[PatIdxW-1:0]]);
  end

  assign byte_o = byte_q;

endmodule

[rtl/core/stream_exact_pattern_matcher_core.sv]
// ----------------------------------------------------------------------------
// stream_exact_pattern_matcher_core
// Finds every occurrence, overlaps included, of a 2..32 byte pattern in a
// byte stream, with start offset per match and a saturating match count.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake      | payload
//  ----------+-----+----------------+------------------------------------------
//  data_i    | in  | valid / ready  | data_byte[7:0], new_file
//  result_o  | out | valid / ready  | match_found, match_start[47:0],
//            |     |                |   match_total[47:0]
//  apb       | in  | psel / penable | paddr[5:0], pwdata[63:0], prdata[63:0]
//
//  One byte per cycle. A byte is compared against the whole window of
//  PATTERN_MAX cells in the cycle it is taken; its result sits in the output
//  register the next cycle. Input ready follows the output register: a stall
//  on result_o holds one result and stops input only while it stays full.
//  Reset clears the window, offset, count and pattern; length resets to 2.
// ----------------------------------------------------------------------------
module stream_exact_pattern_matcher_core import sepm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sepm_in_if.sink             data_i,
  sepm_out_if.source          result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int FillW = $clog2(PATTERN_MAX + 1);

  logic [PatBytes-1:0][7:0]    pat;
  logic [LenW-1:0]             len_cfg;
  logic [LenW-1:0]             len_eff;
  sepm_cell_ctl_t              ctl;
  logic [PATTERN_MAX-1:0][7:0] win;
  logic [PATTERN_MAX-1:0]      eq;

  logic                        in_acc;
  logic [FillW-1:0]            fill_q, fill_d;
  logic [OffW-1:0]             offset_q, offset_d;
  logic [OffW-1:0]             here;
  logic [OffW-1:0]             count_q, count_d;
  logic                        hit;

  logic                        out_v_q;
  logic                        found_q;
  logic [OffW-1:0]             start_q;
  logic [OffW-1:0]             total_q;

  sepm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .pat_o  (pat),
    .len_o  (len_cfg)
  );

  assign data_i.ready = !out_v_q || result_o.ready;
  assign in_acc       = data_i.valid && data_i.ready;

  assign len_eff   = (len_cfg > LenW'(PATTERN_MAX)) ? LenW'(PATTERN_MAX) : len_cfg;
  assign ctl.shift = in_acc;
  assign ctl.clr   = data_i.new_file;
  assign ctl.len   = len_eff;

  // Window chain: cell 0 takes the stream byte, each cell feeds the next
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    if (j == 0) begin : g_head
      sepm_cell #(.Idx(j), .IsHead(1'b1)) u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .ctl_i (ctl),
        .pat_i (pat),
        .nb_i  (data_i.data_byte),
        .byte_o(win[j]),
        .eq_o  (eq[j])
      );
    end else begin : g_body
      sepm_cell #(.Idx(j), .IsHead(1'b0)) u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .ctl_i (ctl),
        .pat_i (pat),
        .nb_i  (win[j-1]),
        .byte_o(win[j]),
        .eq_o  (eq[j])
      );
    end
  end

  always_comb begin
    if (data_i.new_file) begin
      fill_d = FillW'(1);
      here   = '0;
    end else begin
      fill_d = (fill_q == FillW'(PATTERN_MAX)) ? fill_q : fill_q + FillW'(1);
      here   = offset_q;
    end
    offset_d = here + OffW'(1);
    hit      = (len_eff >= LenW'(MinLen)) && (LenW'(fill_d) >= len_eff) && (&eq);
    count_d  = (hit && !(&count_q)) ? count_q + OffW'(1) : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      offset_q <= '0;
      count_q  <= '0;
    end else if (in_acc) begin
      fill_q   <= fill_d;
      offset_q <= offset_d;
      count_q  <= count_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (in_acc) begin
      out_v_q <= 1'b1;
    end else if (result_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      found_q <= hit;
      start_q <= hit ? (here - OffW'(len_eff) + OffW'(1)) : '0;
      total_q <= count_d;
    end
  end

  assign result_o.valid       = out_v_q;
  assign result_o.match_found = found_q;
  assign result_o.match_start = start_q;
  assign result_o.match_total = total_q;

  // Assertions
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !found_q |-> start_q == '0)
    else $error("match_start nonzero without a match");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q >= $past(count_q))
    else $error("match count went backwards");

  a_new_file_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && data_i.new_file |=> fill_q == FillW'(1))
    else $error("window fill not restarted on new file");

  a_hit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && hit |-> LenW'(fill_d) >= LenW'(MinLen))
    else $error("match reported on a short window");

endmodule
